[sv/bloom_filter_murmur2_double_hash_assert.svh]
// Assertion macros shared by the Bloom filter RTL.
`ifndef BLOOM_FILTER_MURMUR2_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_MURMUR2_DOUBLE_HASH_ASSERT_SVH

// The condition must hold whenever the trigger holds.
`define BF_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BF_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[sv/bfmm2_pkg.sv]
`default_nettype none
package bfmm2_pkg;

    localparam int unsigned DEF_MAX_FILTER_BITS = 65536;
    localparam int unsigned DEF_MAX_KEY_BYTES   = 1024;
    localparam int unsigned DEF_MAX_HASHES      = 32;

    localparam logic [31:0] MIX_M      = 32'h5bd1e995;
    localparam int unsigned MIX_R      = 24;
    localparam int unsigned FIN_R1     = 13;
    localparam int unsigned FIN_R2     = 15;
    localparam logic [31:0] FIRST_SEED = 32'h9747b28c;

    localparam int unsigned FSB_W     = 17;
    localparam int unsigned HC_REG_W  = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 1'b1;

    localparam logic [FSB_W-1:0]    FSB_RESET = 17'd65536;
    localparam logic [HC_REG_W-1:0] HC_RESET  = 6'd7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_K1,
        S_K2,
        S_H,
        S_TAIL,
        S_F1,
        S_F2,
        S_MOD,
        S_PRD,
        S_PCHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        op;
        logic [31:0] key_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } t_in_req;

    typedef struct packed {
        logic        already_present;
        logic        key_overflow;
        logic [31:0] added_total;
    } t_out_req;

endpackage
`default_nettype wire

[sv/bloom_filter_murmur2_double_hash.sv]
// A word not marked last is written to the key buffer and the block stays idle for the next
// word. A last word starts two hash passes over the W full key words and the partial tail word,
// if any, then H probes, H the hash count; an overflowed key goes straight to its result.
// The passes share one 32-bit multiplier, and each probe finds its remainder bit-serially.
// Reset is synchronous, active low; afterwards the filter store is swept to zero
// one byte a cycle, and no request is taken during the sweep.
`default_nettype none
module bloom_filter_murmur2_double_hash #(
    parameter int unsigned MAX_FILTER_BITS = bfmm2_pkg::DEF_MAX_FILTER_BITS,
    parameter int unsigned MAX_KEY_BYTES   = bfmm2_pkg::DEF_MAX_KEY_BYTES,
    parameter int unsigned MAX_HASHES      = bfmm2_pkg::DEF_MAX_HASHES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bfmm2_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bfmm2_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire bfmm2_pkg::t_in_req             i_in_req,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output bfmm2_pkg::t_out_req                 o_out_req
);
    import bfmm2_pkg::*;

    `include "bloom_filter_murmur2_double_hash_assert.svh"

    localparam int unsigned LEN_W   = $clog2(MAX_KEY_BYTES + 1);
    localparam int unsigned BK_DEP  = (MAX_KEY_BYTES + 3) / 4;
    localparam int unsigned BK_AW   = (BK_DEP > 1) ? $clog2(BK_DEP) : 1;
    localparam int unsigned FB_W    = $clog2(MAX_FILTER_BITS + 1);
    localparam int unsigned ST_DEP  = (MAX_FILTER_BITS + 7) / 8;
    localparam int unsigned SA_W    = (ST_DEP > 1) ? $clog2(ST_DEP) : 1;
    localparam int unsigned HC_W    = $clog2(MAX_HASHES + 1);
    localparam int unsigned HCC_W   = (HC_W > HC_REG_W) ? HC_W : HC_REG_W;
    localparam int unsigned FBC_W   = (FB_W > FSB_W) ? FB_W : FSB_W;

    t_state r_state, n_state;

    logic [FSB_W-1:0]    r_fsb;
    logic [HC_REG_W-1:0] r_hc;
    logic [LEN_W-1:0]    r_len;
    logic                r_ovf;
    logic [31:0]         r_cnt;
    logic                r_op;
    logic                r_pass;
    logic [LEN_W-1:0]    r_widx;
    logic [31:0]         r_h, r_k, r_a, r_b, r_x, r_mx;
    logic [FB_W-1:0]     r_mod, r_rem;
    logic [HC_W-1:0]     r_probes, r_pi;
    logic [4:0]          r_bit;
    logic                r_allhit;
    logic                r_res_ovf;
    logic [SA_W-1:0]     r_caddr;
    logic                r_ov;
    t_out_req            r_out;

    // Key buffer: four byte lanes, lane = byte address mod 4.
    logic [7:0] r_bk_rd [4];
    logic [31:0] buf_word;
    assign buf_word = {r_bk_rd[3], r_bk_rd[2], r_bk_rd[1], r_bk_rd[0]};

    logic           in_acc;
    logic [2:0]     nb;
    logic [LEN_W:0] len_sum;
    logic [LEN_W-1:0] n_len;
    logic           n_ovf;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign nb      = (i_in_req.valid_bytes > 3'd4) ? 3'd4 : i_in_req.valid_bytes;
    assign len_sum = {1'b0, r_len} + (LEN_W + 1)'(nb);
    assign n_len   = (len_sum > (LEN_W + 1)'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES)
                                                            : len_sum[LEN_W-1:0];
    assign n_ovf   = r_ovf || (len_sum > (LEN_W + 1)'(MAX_KEY_BYTES));

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [7:0]     mem [BK_DEP];
        logic [1:0]     j;
        logic [LEN_W:0] pos;
        logic           we;
        assign j   = 2'(g) - r_len[1:0];
        assign pos = {1'b0, r_len} + (LEN_W + 1)'(j);
        assign we  = in_acc && ({1'b0, j} < nb) && (pos < (LEN_W + 1)'(MAX_KEY_BYTES));
        always_ff @(posedge i_clk) begin
            if (we) begin
                mem[pos[BK_AW+1:2]] <= i_in_req.key_word[8*j +: 8];
            end
            r_bk_rd[g] <= mem[r_widx[BK_AW-1:0]];
        end
    end

    // Filter store with one read and one write port.
    logic [7:0]      st_mem [ST_DEP];
    logic [7:0]      r_sdata;
    logic            st_we;
    logic [SA_W-1:0] st_wa, st_ra;
    logic [7:0]      st_wd;
    logic            hit;

    assign st_ra = SA_W'(r_rem >> 3);
    assign hit   = r_sdata[r_rem[2:0]];

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_wa] <= st_wd;
        end
        r_sdata <= st_mem[st_ra];
    end

    // Shared multiplier: every product in the hash is by the mixing constant.
    logic [31:0] mop, mres;
    logic [63:0] mprod;
    logic [31:0] tail_mask;
    logic [31:0] h_fin;
    logic [FB_W:0] rem_t;
    logic [FB_W-1:0] rem_n;
    logic [LEN_W-1:0] nwords;
    logic            last_probe;
    logic [HCC_W-1:0] hc_ext;
    logic [FBC_W-1:0] fsb_ext;

    assign mprod = {32'd0, mop} * {32'd0, MIX_M};
    assign mres  = mprod[31:0];
    assign h_fin = r_h ^ (r_h >> FIN_R2);
    assign rem_t = {r_rem, r_mx[31]};
    assign rem_n = (rem_t >= {1'b0, r_mod}) ? FB_W'(rem_t - {1'b0, r_mod}) : rem_t[FB_W-1:0];
    assign nwords = r_len >> 2;
    assign last_probe = (r_pi + HC_W'(1)) == r_probes;
    assign hc_ext  = HCC_W'(r_hc);
    assign fsb_ext = FBC_W'(r_fsb);

    always_comb begin
        case (r_len[1:0])
            2'd1:    tail_mask = 32'h0000_00ff;
            2'd2:    tail_mask = 32'h0000_ffff;
            2'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'h0000_0000;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_caddr == SA_W'(ST_DEP - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc && i_in_req.last_word) begin
                    n_state = n_ovf ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                if (r_widx < nwords)         n_state = S_K1;
                else if (r_len[1:0] != 2'd0) n_state = S_TAIL;
                else                         n_state = S_F1;
            end
            S_K1:   n_state = S_K2;
            S_K2:   n_state = S_H;
            S_H:    n_state = S_RD;
            S_TAIL: n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = r_pass ? S_MOD : S_RD;
            S_MOD:  if (r_bit == 5'd31) n_state = S_PRD;
            S_PRD:  n_state = S_PCHK;
            S_PCHK: n_state = last_probe ? S_DONE : S_MOD;
            S_DONE: if (!r_ov || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath controls.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        st_we = 1'b0;
        st_wa = st_ra;
        st_wd = r_sdata | (8'd1 << r_rem[2:0]);
        unique case (r_state)
            S_K1:    mop = buf_word;
            S_K2:    mop = r_k ^ (r_k >> MIX_R);
            S_TAIL:  mop = r_h ^ (buf_word & tail_mask);
            S_F1:    mop = r_h ^ (r_h >> FIN_R1);
            default: mop = r_h;
        endcase
        unique case (r_state)
            S_CLEAR: begin
                st_we = 1'b1;
                st_wa = r_caddr;
                st_wd = 8'd0;
            end
            S_PCHK:  st_we = r_op && !hit;
            default: st_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fsb   <= FSB_RESET;
            r_hc    <= HC_RESET;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
            r_caddr <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FILTER_SIZE: r_fsb <= i_cfg_data[FSB_W-1:0];
                    CFG_HASH_COUNT:  r_hc  <= i_cfg_data[HC_REG_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_caddr <= r_caddr + SA_W'(1);
            end
            if (in_acc) begin
                r_len <= n_len;
                r_ovf <= n_ovf;
            end
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DONE && (!r_ov || !i_out_stall)) begin
                r_ov  <= 1'b1;
                r_len <= '0;
                r_ovf <= 1'b0;
                if (!r_res_ovf && r_op && !r_allhit) begin
                    r_cnt <= r_cnt + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op      <= i_in_req.op;
                r_pass    <= 1'b0;
                r_widx    <= '0;
                r_h       <= FIRST_SEED ^ 32'(n_len);
                r_res_ovf <= n_ovf;
                r_allhit  <= 1'b0;
                if (fsb_ext == '0)                          r_mod <= FB_W'(1);
                else if (fsb_ext > FBC_W'(MAX_FILTER_BITS)) r_mod <= FB_W'(MAX_FILTER_BITS);
                else                                        r_mod <= FB_W'(r_fsb);
                if (hc_ext == '0)                           r_probes <= HC_W'(1);
                else if (hc_ext > HCC_W'(MAX_HASHES))       r_probes <= HC_W'(MAX_HASHES);
                else                                        r_probes <= HC_W'(r_hc);
            end
            S_K1, S_K2: r_k <= mres;
            S_H: begin
                r_h    <= mres ^ r_k;
                r_widx <= r_widx + LEN_W'(1);
            end
            S_TAIL, S_F1: r_h <= mres;
            S_F2: begin
                if (!r_pass) begin
                    r_a    <= h_fin;
                    r_h    <= h_fin ^ 32'(r_len);
                    r_pass <= 1'b1;
                    r_widx <= '0;
                end else begin
                    r_b      <= h_fin;
                    r_mx     <= r_a;
                    r_x      <= r_a + h_fin;
                    r_rem    <= '0;
                    r_bit    <= '0;
                    r_pi     <= '0;
                    r_allhit <= 1'b1;
                end
            end
            S_MOD: begin
                r_rem <= rem_n;
                r_mx  <= {r_mx[30:0], 1'b0};
                r_bit <= r_bit + 5'd1;
            end
            S_PCHK: begin
                r_allhit <= r_allhit && hit;
                r_pi     <= r_pi + HC_W'(1);
                r_mx     <= r_x;
                r_x      <= r_x + r_b;
                r_rem    <= '0;
                r_bit    <= '0;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    r_out.already_present <= !r_res_ovf && r_allhit;
                    r_out.key_overflow    <= r_res_ovf;
                    r_out.added_total     <= r_cnt + 32'((!r_res_ovf && r_op && !r_allhit));
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_req   = r_out;

    `BF_ASSERT_NOW(a_clear_blocks, r_state == S_CLEAR, o_in_stall, "request taken during clear")
    `BF_ASSERT_NOW(a_len_bound, 1'b1, r_len <= LEN_W'(MAX_KEY_BYTES), "key length past buffer")
    `BF_ASSERT_NOW(a_probe_bound, r_state == S_PCHK, r_pi < r_probes, "probe count overrun")
    `BF_ASSERT_NEXT(a_done_out, r_state == S_DONE && n_state == S_IDLE, o_out_valid,
        "result not presented")

endmodule
`default_nettype wire

[dv/bloom_filter_murmur2_double_hash_tb.sv]
`default_nettype none
module bloom_filter_murmur2_double_hash_tb;
    import bfmm2_pkg::*;

    localparam int unsigned FILTER_BITS = DEF_MAX_FILTER_BITS;
    localparam int unsigned KEY_BYTES   = DEF_MAX_KEY_BYTES;
    localparam int unsigned HASH_LIMIT  = DEF_MAX_HASHES;
    localparam int unsigned TARGET_ITEMS = 1600;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_FILTER_SIZE;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_req              in_req = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_req             out_req;

    bloom_filter_murmur2_double_hash u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_req  (out_req)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the filter state.
    bit          bit_store [FILTER_BITS];
    logic [7:0]  key_bytes [KEY_BYTES];
    int unsigned key_len;
    bit          key_ovf;
    logic [31:0] add_count;
    logic [16:0] size_reg;
    logic [5:0]  probes_reg;

    t_in_req  pending_words[$];
    t_out_req expected_results[$];
    int unsigned errors = 0;
    int unsigned items_made = 0;
    int unsigned keys_checked = 0;
    int unsigned hits_seen = 0;
    int unsigned overflows_seen = 0;
    bit hold_sender = 1'b0;

    function automatic logic [31:0] murmur2(int unsigned len, logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        int unsigned pos;
        int unsigned left;
        h = seed ^ len;
        pos = 0;
        left = len;
        while (left >= 4) begin
            k = {key_bytes[pos+3], key_bytes[pos+2], key_bytes[pos+1], key_bytes[pos]};
            k = k * MIX_M;
            k = k ^ (k >> MIX_R);
            k = k * MIX_M;
            h = h * MIX_M;
            h = h ^ k;
            pos += 4;
            left -= 4;
        end
        if (left == 3) h = h ^ ({24'd0, key_bytes[pos+2]} << 16);
        if (left >= 2) h = h ^ ({24'd0, key_bytes[pos+1]} << 8);
        if (left >= 1) begin
            h = h ^ {24'd0, key_bytes[pos]};
            h = h * MIX_M;
        end
        h = h ^ (h >> FIN_R1);
        h = h * MIX_M;
        h = h ^ (h >> FIN_R2);
        return h;
    endfunction

    // Advances the shadow state by one accepted request.
    function automatic void absorb_word(t_in_req r);
        int unsigned nb;
        int unsigned bits;
        int unsigned probes;
        logic [31:0] ha;
        logic [31:0] hb;
        logic [31:0] pos;
        logic [31:0] idx;
        int unsigned hits;
        t_out_req res;
        nb = (r.valid_bytes > 4) ? 4 : r.valid_bytes;
        for (int i = 0; i < nb; i++) begin
            if (key_len < KEY_BYTES) begin
                key_bytes[key_len] = r.key_word[8*i +: 8];
                key_len++;
            end else begin
                key_ovf = 1'b1;
            end
        end
        if (r.last_word) begin
            res = '0;
            res.key_overflow = key_ovf;
            if (!key_ovf) begin
                bits = (size_reg == 0) ? 1 :
                       (size_reg > FILTER_BITS) ? FILTER_BITS : size_reg;
                probes = (probes_reg == 0) ? 1 :
                         (probes_reg > HASH_LIMIT) ? HASH_LIMIT : probes_reg;
                ha = murmur2(key_len, FIRST_SEED);
                hb = murmur2(key_len, ha);
                hits = 0;
                for (int unsigned i = 0; i < probes; i++) begin
                    idx = i;
                    pos = (ha + idx * hb) % bits;
                    if (bit_store[pos]) hits++;
                    else if (r.op) bit_store[pos] = 1'b1;
                end
                if (hits == probes) res.already_present = 1'b1;
                else if (r.op) add_count = add_count + 32'd1;
            end
            res.added_total = add_count;
            expected_results.push_back(res);
            key_len = 0;
            key_ovf = 1'b0;
        end
    endfunction

    // Sender: one request at a time from the pending queue, random gaps between.
    int unsigned send_gap = 0;
    bit send_burst = 1'b0;
    always @(posedge i_clk) begin
        logic busy;
        busy = in_valid && in_stall;
        if (in_valid && !in_stall) absorb_word(in_req);
        if (!busy) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (!hold_sender && pending_words.size() > 0) begin
                in_req <= pending_words.pop_front();
                in_valid <= 1'b1;
                if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each result, with quiet stretches.
    int unsigned recv_wait = 0;
    bit recv_burst = 1'b0;
    always @(posedge i_clk) begin
        t_out_req want;
        if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, out_req);
            end else begin
                want = expected_results.pop_front();
                keys_checked++;
                if (out_req.already_present) hits_seen++;
                if (out_req.key_overflow) overflows_seen++;
                if (out_req !== want) begin
                    errors++;
                    $display("%0t: result differs: expected present=%0d ovf=%0d total=%0d,",
                             $time, want.already_present, want.key_overflow,
                             want.added_total);
                    $display("    got present=%0d ovf=%0d total=%0d",
                             out_req.already_present, out_req.key_overflow,
                             out_req.added_total);
                end
            end
            if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
            recv_wait = recv_burst ? 0 : $urandom_range(0, 5);
        end
        if (recv_wait > 0) begin
            recv_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Recently sent keys, replayed so that lookups find members.
    t_in_req     key_bank [16][8];
    int unsigned bank_len [16];
    int unsigned bank_fill = 0;

    task automatic queue_key(bit op, int unsigned nwords, bit wide_valid);
        t_in_req w;
        int unsigned slot;
        slot = bank_fill % 16;
        for (int unsigned i = 0; i < nwords; i++) begin
            w.op = op;
            w.key_word = $urandom();
            w.last_word = (i == nwords - 1);
            if (w.last_word || wide_valid) w.valid_bytes = 3'($urandom_range(0, 7));
            else w.valid_bytes = 3'd4;
            pending_words.push_back(w);
            if (nwords <= 8) key_bank[slot][i] = w;
        end
        items_made += nwords;
        if (nwords <= 8) begin
            bank_len[slot] = nwords;
            bank_fill++;
        end
    endtask

    task automatic replay_key(bit op);
        int unsigned slot;
        t_in_req w;
        if (bank_fill == 0) return;
        slot = $urandom_range(0, ((bank_fill < 16) ? bank_fill : 16) - 1);
        for (int unsigned i = 0; i < bank_len[slot]; i++) begin
            w = key_bank[slot][i];
            w.op = op;
            pending_words.push_back(w);
        end
        items_made += bank_len[slot];
    endtask

    task automatic queue_word(bit op, logic [31:0] data, logic [2:0] nb, bit last);
        t_in_req w;
        w.op = op;
        w.key_word = data;
        w.valid_bytes = nb;
        w.last_word = last;
        pending_words.push_back(w);
        items_made++;
    endtask

    // Waits until the block has no request in flight and then lets it settle.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        if (idx == CFG_FILTER_SIZE) size_reg = value;
        else probes_reg = value[5:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_keys(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_made + count;
        while (items_made < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) queue_key(1'($urandom_range(0, 1)), $urandom_range(1, 4), 1'b0);
            else if (pick < 70) queue_key(1'($urandom_range(0, 1)), $urandom_range(1, 8), 1'b1);
            else if (pick < 97) replay_key(1'($urandom_range(0, 1)));
            else if (pick < 99) queue_word(1'($urandom_range(0, 1)), $urandom(), 3'd0, 1'b1);
            else queue_key(1'($urandom_range(0, 1)), $urandom_range(257, 260), 1'b0);
        end
    endtask

    initial begin
        for (int i = 0; i < FILTER_BITS; i++) bit_store[i] = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) key_bytes[i] = 8'd0;
        key_len = 0;
        key_ovf = 1'b0;
        add_count = '0;
        size_reg = FSB_RESET;
        probes_reg = HC_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration.
        queue_word(1'b0, 32'h0, 3'd0, 1'b1);          // empty key, lookup
        queue_word(1'b1, 32'h0, 3'd0, 1'b1);          // empty key, add
        queue_word(1'b1, 32'h0, 3'd0, 1'b1);          // empty key, now a member
        queue_word(1'b1, 32'hFFFFFFFF, 3'd4, 1'b1);
        queue_word(1'b0, 32'hFFFFFFFF, 3'd4, 1'b1);
        queue_word(1'b1, 32'h000000A5, 3'd1, 1'b1);
        queue_word(1'b1, 32'h0000BEEF, 3'd2, 1'b1);
        queue_word(1'b1, 32'h00C0FFEE, 3'd3, 1'b1);
        queue_word(1'b1, 32'h12345678, 3'd7, 1'b1);   // more than four means four
        queue_word(1'b1, 32'hDEADBEEF, 3'd4, 1'b0);
        queue_word(1'b1, 32'h00000077, 3'd1, 1'b0);   // partial word mid-key
        queue_word(1'b1, 32'hCAFEF00D, 3'd5, 1'b1);
        queue_word(1'b0, 32'hDEADBEEF, 3'd4, 1'b0);
        queue_word(1'b0, 32'h00000077, 3'd1, 1'b0);
        queue_word(1'b0, 32'hCAFEF00D, 3'd6, 1'b1);
        queue_key(1'b1, 256, 1'b0);                   // fills the buffer when the last word holds four bytes
        queue_key(1'b1, 257, 1'b0);                   // one word more; overflows unless the last word is empty
        drain();

        // The sender holds until every result is back, then resumes.
        random_keys(200);
        repeat (3000) @(posedge i_clk);
        hold_sender <= 1'b1;
        do @(posedge i_clk);
        while (in_valid || expected_results.size() != 0);
        hold_sender <= 1'b0;
        drain();
        random_keys(100);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'd1);
        write_reg(CFG_HASH_COUNT, 17'd1);
        random_keys(100);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'd0);
        write_reg(CFG_HASH_COUNT, 17'd32);
        random_keys(100);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'h1FFFF);
        write_reg(CFG_HASH_COUNT, 17'd63);
        random_keys(150);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'd100);
        write_reg(CFG_HASH_COUNT, 17'd0);
        random_keys(150);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'd65536);
        write_reg(CFG_HASH_COUNT, 17'd32);
        random_keys(150);
        drain();

        write_reg(CFG_FILTER_SIZE, 17'(($urandom_range(1, 2000))));
        write_reg(CFG_HASH_COUNT, 17'(($urandom_range(1, 12))));
        random_keys((items_made + 50 < TARGET_ITEMS) ? TARGET_ITEMS - items_made : 50);
        drain();

        $display("Sent %0d requests, checked %0d keys: %0d already present, %0d overflowed.",
                 items_made, keys_checked, hits_seen, overflows_seen);
        if (errors == 0) begin
            $display("bloom_filter_murmur2_double_hash: match");
        end else begin
            $display("bloom_filter_murmur2_double_hash: mismatch");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("Run timed out with %0d results outstanding.", expected_results.size());
        $display("bloom_filter_murmur2_double_hash: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

[bloom_filter_murmur2_double_hash.f]
+incdir+sv
sv/bfmm2_pkg.sv
sv/bloom_filter_murmur2_double_hash.sv
dv/bloom_filter_murmur2_double_hash_tb.sv
